FILE: src/tia_pkg.sv
// ----------------------------------------------------------------------------
// tia_pkg
// Shared widths, opcodes, error codes and sequencer types of the tagged ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package tia_pkg;

    // Arithmetic width; port values stay 64 bits, sign-extended from it
    localparam int DATA_WIDTH = 64;
    localparam int VALUE_W    = 64;
    localparam int OP_W       = 3;
    localparam int ERR_W      = 2;
    // bit counter of the iterative unit, also holds an in-range exponent
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int BIT_W      = $clog2(CNT_W);

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_POW = 3'd5
    } t_op;

    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_OP   = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ABS_B,
        ST_MUL,
        ST_MUL_END,
        ST_DIV,
        ST_POW_SQ,
        ST_POW_BM,
        ST_POW_NEXT,
        ST_SIGN,
        ST_FINISH
    } t_state;

    // operand selection of the shared adder
    typedef enum logic [2:0] {
        AS_ADD,
        AS_SUB,
        AS_MUL_STEP,
        AS_DIV_STEP,
        AS_NEG_A,
        AS_NEG_B,
        AS_NEG_RES,
        AS_CMP_LIM
    } t_add_sel;

endpackage

`default_nettype wire

FILE: src/tia_in_if.sv
// ----------------------------------------------------------------------------
// tia_in_if
// Operand channel: opcode and two tagged operands, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tia_in_if;
    import tia_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic                      a_is_error;
    logic signed [VALUE_W-1:0] a_value;
    logic [ERR_W-1:0]          a_error_code;
    logic                      b_is_error;
    logic signed [VALUE_W-1:0] b_value;
    logic [ERR_W-1:0]          b_error_code;

    modport source (
        output valid, op, a_is_error, a_value, a_error_code,
               b_is_error, b_value, b_error_code,
        input  ready
    );

    modport sink (
        input  valid, op, a_is_error, a_value, a_error_code,
               b_is_error, b_value, b_error_code,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/tia_out_if.sv
// ----------------------------------------------------------------------------
// tia_out_if
// Result channel: one tagged result per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tia_out_if;
    import tia_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      res_is_error;
    logic signed [VALUE_W-1:0] res_value;
    logic [ERR_W-1:0]          res_error_code;

    modport source (
        output valid, res_is_error, res_value, res_error_code,
        input  ready
    );

    modport sink (
        input  valid, res_is_error, res_value, res_error_code,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/tagged_integer_alu_core.sv
// ----------------------------------------------------------------------------
// tagged_integer_alu_core
// Tagged integer ALU: add, sub, mul, div, rem and saturating power.
//
// i_in carries an opcode and two tagged operands; o_out returns one tagged
// result per item. Both channels move an item when valid and ready are high.
// All arithmetic runs through one DATA_WIDTH+1 bit adder under a small
// sequencer, one bit per cycle for multiply and divide.
// Sequencer steps from accept to result, each path ending in finish:
//   error pass-through, bad opcode, add, sub, zero divisor: decode
//   mul: decode, multiply steps; div/rem: decode, divisor magnitude,
//   divide steps, sign; power: decode alone for trivial cases, else
//   square-and-multiply over the exponent bits, then sign unless saturated.
// i_in.ready is high only while the sequencer is idle, so no item is taken
// while one is in work; the next is accepted the cycle after a result moves
// into the output register, even if it is still waiting for the receiver.
// A stalled receiver holds the result; the sequencer then waits with the next
// one finished. Reset (synchronous, active low) empties the output register,
// holds i_in.ready low and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_integer_alu_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tia_in_if.sink    i_in,
    tia_out_if.source o_out
);
    import tia_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] VAL_ONE  = W'(1);
    localparam logic [W-1:0] VAL_ALL1 = '1;
    localparam logic [W-1:0] VAL_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VAL_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] VAL_W    = W'(W);

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    logic               r_a_err, n_a_err, r_b_err, n_b_err;
    logic [ERR_W-1:0]   r_a_code, n_a_code, r_b_code, n_b_code;
    logic [W-1:0]       r_a, n_a, r_b, n_b;
    logic [W-1:0]       r_mc, n_mc, r_hi, n_hi, r_lo, n_lo;
    logic [W-1:0]       r_acc, n_acc, r_base, n_base, r_res, n_res;
    logic [CNT_W-1:0]   r_cnt, n_cnt, r_exp, n_exp;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_sq, n_sq, r_neg, n_neg;
    logic               r_res_err, n_res_err;
    logic [ERR_W-1:0]   r_res_code, n_res_code;

    logic               r_out_valid;
    logic               r_out_err;
    logic [ERR_W-1:0]   r_out_code;
    logic [VALUE_W-1:0] r_out_val;

    t_add_sel           add_sel;
    logic [W:0]         add_x, add_y, add_sum;
    logic               add_cin;

    logic               a_neg, b_neg, pow_neg, b_big, pow_loop, ovf, borrow, out_load;
    logic [W-1:0]       limit, pow_special, sign_src;

    // ---------------------------------------------------------------- conditions
    assign a_neg    = r_a[W-1];
    assign b_neg    = r_b[W-1];
    assign pow_neg  = a_neg & r_b[0];
    assign b_big    = (r_b >= VAL_W);
    assign pow_loop = !b_neg && (r_b != '0) && (r_a != '0) && (r_a != VAL_ONE)
                      && (r_a != VAL_ALL1) && !b_big;
    assign limit    = r_neg ? VAL_MIN : VAL_MAX;
    // product overflows when the high half is set or the low half is above limit
    assign ovf      = (r_hi != '0) | add_sum[W];
    assign borrow   = add_sum[W];
    assign out_load = (r_state == ST_FINISH) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (b_neg) begin
            if (r_a == VAL_ONE) begin
                pow_special = VAL_ONE;
            end else if (r_a == VAL_ALL1) begin
                pow_special = r_b[0] ? VAL_ALL1 : VAL_ONE;
            end else begin
                pow_special = '0;
            end
        end else if (r_b == '0) begin
            pow_special = VAL_ONE;
        end else if (r_a == '0) begin
            pow_special = '0;
        end else if (r_a == VAL_ONE) begin
            pow_special = VAL_ONE;
        end else if (r_a == VAL_ALL1) begin
            pow_special = pow_neg ? VAL_ALL1 : VAL_ONE;
        end else begin
            // magnitude at least two and exponent at least W: always saturates
            pow_special = pow_neg ? VAL_MIN : VAL_MAX;
        end
    end

    always_comb begin
        case (r_op)
            OP_DIV:  sign_src = r_lo;
            OP_REM:  sign_src = r_hi;
            default: sign_src = r_acc;
        endcase
    end

    // ---------------------------------------------------------------- shared adder
    always_comb begin
        add_x   = {1'b0, r_a};
        add_y   = {1'b0, r_b};
        add_cin = 1'b0;
        case (add_sel)
            AS_ADD: begin
                add_x = {1'b0, r_a};
                add_y = {1'b0, r_b};
            end
            AS_SUB: begin
                add_y   = {1'b1, ~r_b};
                add_cin = 1'b1;
            end
            AS_MUL_STEP: begin
                add_x = {1'b0, r_hi};
                add_y = {1'b0, (r_lo[0] ? r_mc : '0)};
            end
            AS_DIV_STEP: begin
                // partial remainder stays below the divisor, so its top bit is clear
                add_x   = {1'b0, r_hi[W-2:0], r_lo[W-1]};
                add_y   = {1'b1, ~r_mc};
                add_cin = 1'b1;
            end
            AS_NEG_A: begin
                add_x   = '0;
                add_y   = {1'b1, ~r_a};
                add_cin = 1'b1;
            end
            AS_NEG_B: begin
                add_x   = '0;
                add_y   = {1'b1, ~r_b};
                add_cin = 1'b1;
            end
            AS_NEG_RES: begin
                add_x   = '0;
                add_y   = {1'b1, ~sign_src};
                add_cin = 1'b1;
            end
            AS_CMP_LIM: begin
                add_x   = {1'b0, limit};
                add_y   = {1'b1, ~r_lo};
                add_cin = 1'b1;
            end
            default: begin
                add_x = {1'b0, r_a};
                add_y = {1'b0, r_b};
            end
        endcase
        add_sum = add_x + add_y + {{W{1'b0}}, add_cin};
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_a_err || r_b_err) begin
                    n_state = ST_FINISH;
                end else begin
                    case (r_op)
                        OP_MUL:  n_state = ST_MUL;
                        OP_DIV:  n_state = (r_b == '0) ? ST_FINISH : ST_ABS_B;
                        OP_REM:  n_state = (r_b == '0) ? ST_FINISH : ST_ABS_B;
                        OP_POW:  n_state = pow_loop ? ST_POW_SQ : ST_FINISH;
                        default: n_state = ST_FINISH;
                    endcase
                end
            end
            ST_ABS_B:    n_state = ST_DIV;
            ST_MUL: begin
                if (r_cnt == '0) n_state = ST_MUL_END;
            end
            ST_MUL_END: begin
                if (r_op == OP_MUL || ovf) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = r_sq ? ST_POW_BM : ST_POW_NEXT;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) n_state = ST_SIGN;
            end
            ST_POW_SQ:   n_state = (r_acc == VAL_ONE) ? ST_POW_BM : ST_MUL;
            ST_POW_BM:   n_state = r_exp[r_bit] ? ST_MUL : ST_POW_NEXT;
            ST_POW_NEXT: n_state = (r_bit == '0) ? ST_SIGN : ST_POW_SQ;
            ST_SIGN:     n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath control
    always_comb begin
        add_sel    = AS_ADD;
        n_op       = r_op;
        n_a_err    = r_a_err;
        n_b_err    = r_b_err;
        n_a_code   = r_a_code;
        n_b_code   = r_b_code;
        n_a        = r_a;
        n_b        = r_b;
        n_mc       = r_mc;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_acc      = r_acc;
        n_base     = r_base;
        n_res      = r_res;
        n_cnt      = r_cnt;
        n_exp      = r_exp;
        n_bit      = r_bit;
        n_sq       = r_sq;
        n_neg      = r_neg;
        n_res_err  = r_res_err;
        n_res_code = r_res_code;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op     = i_in.op;
                    n_a_err  = i_in.a_is_error;
                    n_a_code = i_in.a_error_code;
                    n_a      = i_in.a_value[W-1:0];
                    n_b_err  = i_in.b_is_error;
                    n_b_code = i_in.b_error_code;
                    n_b      = i_in.b_value[W-1:0];
                end
            end
            ST_DECODE: begin
                n_res_err  = 1'b0;
                n_res_code = '0;
                n_res      = '0;
                if (r_a_err) begin
                    n_res_err  = 1'b1;
                    n_res_code = r_a_code;
                end else if (r_b_err) begin
                    n_res_err  = 1'b1;
                    n_res_code = r_b_code;
                end else begin
                    case (r_op)
                        OP_ADD: begin
                            add_sel = AS_ADD;
                            n_res   = add_sum[W-1:0];
                        end
                        OP_SUB: begin
                            add_sel = AS_SUB;
                            n_res   = add_sum[W-1:0];
                        end
                        OP_MUL: begin
                            n_mc  = r_a;
                            n_lo  = r_b;
                            n_hi  = '0;
                            n_cnt = CNT_W'(W-1);
                        end
                        OP_DIV, OP_REM: begin
                            if (r_b == '0) begin
                                n_res_err  = 1'b1;
                                n_res_code = ERR_DIV_ZERO;
                            end else begin
                                add_sel = AS_NEG_A;
                                n_lo    = a_neg ? add_sum[W-1:0] : r_a;
                                n_hi    = '0;
                                n_cnt   = CNT_W'(W-1);
                                n_neg   = (r_op == OP_DIV) ? (a_neg ^ b_neg) : a_neg;
                            end
                        end
                        OP_POW: begin
                            add_sel = AS_NEG_A;
                            n_base  = a_neg ? add_sum[W-1:0] : r_a;
                            n_acc   = VAL_ONE;
                            n_exp   = r_b[CNT_W-1:0];
                            n_bit   = BIT_W'(CNT_W-1);
                            n_neg   = pow_neg;
                            n_res   = pow_special;
                        end
                        default: begin
                            n_res_err  = 1'b1;
                            n_res_code = ERR_BAD_OP;
                        end
                    endcase
                end
            end
            ST_ABS_B: begin
                add_sel = AS_NEG_B;
                n_mc    = b_neg ? add_sum[W-1:0] : r_b;
            end
            ST_MUL: begin
                // {hi, lo} shifts right, product bits enter at the top of lo
                add_sel = AS_MUL_STEP;
                n_hi    = add_sum[W:1];
                n_lo    = {add_sum[0], r_lo[W-1:1]};
                n_cnt   = r_cnt - CNT_W'(1);
            end
            ST_MUL_END: begin
                if (r_op == OP_MUL) begin
                    n_res = r_lo;
                end else begin
                    add_sel = AS_CMP_LIM;
                    if (ovf) begin
                        n_res = r_neg ? VAL_MIN : VAL_MAX;
                    end else begin
                        n_acc = r_lo;
                    end
                end
            end
            ST_DIV: begin
                add_sel = AS_DIV_STEP;
                n_hi    = borrow ? {r_hi[W-2:0], r_lo[W-1]} : add_sum[W-1:0];
                n_lo    = {r_lo[W-2:0], ~borrow};
                n_cnt   = r_cnt - CNT_W'(1);
            end
            ST_POW_SQ: begin
                if (r_acc != VAL_ONE) begin
                    n_mc  = r_acc;
                    n_lo  = r_acc;
                    n_hi  = '0;
                    n_cnt = CNT_W'(W-1);
                    n_sq  = 1'b1;
                end
            end
            ST_POW_BM: begin
                if (r_exp[r_bit]) begin
                    n_mc  = r_base;
                    n_lo  = r_acc;
                    n_hi  = '0;
                    n_cnt = CNT_W'(W-1);
                    n_sq  = 1'b0;
                end
            end
            ST_POW_NEXT: begin
                if (r_bit != '0) n_bit = r_bit - BIT_W'(1);
            end
            ST_SIGN: begin
                add_sel = AS_NEG_RES;
                n_res   = r_neg ? add_sum[W-1:0] : sign_src;
            end
            default: begin
                add_sel = AS_ADD;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_a_err    <= n_a_err;
        r_b_err    <= n_b_err;
        r_a_code   <= n_a_code;
        r_b_code   <= n_b_code;
        r_a        <= n_a;
        r_b        <= n_b;
        r_mc       <= n_mc;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_res      <= n_res;
        r_cnt      <= n_cnt;
        r_exp      <= n_exp;
        r_bit      <= n_bit;
        r_sq       <= n_sq;
        r_neg      <= n_neg;
        r_res_err  <= n_res_err;
        r_res_code <= n_res_code;
        if (out_load) begin
            r_out_err  <= r_res_err;
            r_out_code <= r_res_code;
            r_out_val  <= VALUE_W'($signed(r_res));
        end
    end

    // no item is taken while reset is held
    assign i_in.ready           = (r_state == ST_IDLE) && i_rst_n;
    assign o_out.valid          = r_out_valid;
    assign o_out.res_is_error   = r_out_err;
    assign o_out.res_error_code = r_out_code;
    assign o_out.res_value      = r_out_val;

    // ---------------------------------------------------------------- assertions
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == ST_DECODE)
        else $error("accepted item did not enter decode");

    a_div_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_hi < r_mc)
        else $error("partial remainder not below divisor");

    a_pow_acc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POW_SQ || r_state == ST_POW_BM) |-> r_acc <= limit)
        else $error("power accumulator beyond saturation limit");

    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && r_out_valid && !o_out.ready |=> r_state == ST_FINISH)
        else $error("result left finish while output register was full");

endmodule

`default_nettype wire
